// ===== hw/rtl/dtcf_pkg.sv =====
// ----------------------------------------------------------------------------
// dtcf_pkg: shared definitions of the tail cancellation filter
// Widths, fixed coefficient bits, register indexes and the structs that
// pass between the configuration bank, the controller and the datapath.
// ----------------------------------------------------------------------------
package dtcf_pkg;

    // Sample and coefficient formats.
    localparam int SAMPLE_BITS    = 12;
    localparam int COEF_FRAC_BITS = 11;
    localparam int COEF_BITS      = 11;
    localparam int PROD_BITS      = COEF_BITS + SAMPLE_BITS;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};

    // Fixed high bits of the coefficients.
    localparam logic [COEF_BITS-1:0] LAM_L_FIXED   = 11'h600;
    localparam logic [COEF_BITS-1:0] LAM_S_FIXED   = 11'h200;
    localparam logic [COEF_BITS-1:0] ALPHA_S_FIXED = 11'h400;

    // Configuration port.
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 12;

    localparam logic [CFG_IDX_BITS-1:0] CFG_ALPHA_LONG   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ALPHA_SHORT  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LAMBDA_LONG  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LAMBDA_SHORT = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_USE_SHORT    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INIT_LONG    = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INIT_SHORT   = 3'd6;

    // Contents of the configuration bank.
    typedef struct packed {
        logic [9:0]             alpha_long;
        logic [9:0]             alpha_short_param;
        logic [8:0]             lambda_long_param;
        logic [8:0]             lambda_short_param;
        logic                   use_short;
        logic [SAMPLE_BITS-1:0] init_rem_long;
        logic [SAMPLE_BITS-1:0] init_rem_short;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;   // capture the incoming sample
        logic calc_h;    // correction, output and first multiply
        logic finish;    // decay multiply, update remainders, load result
    } ctrl_cmd_t;

endpackage

// ===== hw/rtl/dtcf_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// dtcf_cfg_regs: configuration register bank
// Holds the coefficient and starting remainder registers written through
// the plain write port. Writes to unused indexes are ignored.
// ----------------------------------------------------------------------------
module dtcf_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [dtcf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [dtcf_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
    output dtcf_pkg::cfg_t                     cfg
);
    import dtcf_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register index and update the addressed field.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ALPHA_LONG:   cfg_next.alpha_long         = cfg_wdata[9:0];
                CFG_ALPHA_SHORT:  cfg_next.alpha_short_param  = cfg_wdata[9:0];
                CFG_LAMBDA_LONG:  cfg_next.lambda_long_param  = cfg_wdata[8:0];
                CFG_LAMBDA_SHORT: cfg_next.lambda_short_param = cfg_wdata[8:0];
                CFG_USE_SHORT:    cfg_next.use_short          = cfg_wdata[0];
                CFG_INIT_LONG:    cfg_next.init_rem_long      = cfg_wdata[SAMPLE_BITS-1:0];
                CFG_INIT_SHORT:   cfg_next.init_rem_short     = cfg_wdata[SAMPLE_BITS-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    // All registers reset to zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/dtcf_ctrl.sv =====
// ----------------------------------------------------------------------------
// dtcf_ctrl: sequencing controller
// Steps each sample through the two multiply stages and owns the valid
// flag of the result register.
// ----------------------------------------------------------------------------
module dtcf_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output dtcf_pkg::ctrl_cmd_t cmd
);
    import dtcf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MUL1 = 3'b010,
        ST_MUL2 = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;
    logic   in_xfer;

    // The result register can take a new value when empty or being emptied.
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) || ((state_reg == ST_MUL2) && out_free);
    assign in_xfer  = s_valid && s_ready;

    // Commands to the datapath.
    always_comb begin
        cmd.load_in = in_xfer;
        cmd.calc_h  = (state_reg == ST_MUL1);
        cmd.finish  = (state_reg == ST_MUL2) && out_free;
    end

    // Next state; a new sample may enter while the previous one finishes.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) state_next = ST_MUL1;
            end
            ST_MUL1: begin
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                if (out_free) state_next = in_xfer ? ST_MUL1 : ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Result valid flag.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.finish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== hw/rtl/dtcf_datapath.sv =====
// ----------------------------------------------------------------------------
// dtcf_datapath: filter arithmetic
// Forms the correction and the filtered sample, then updates both
// remainders with the alpha multiply followed by the lambda multiply.
// ----------------------------------------------------------------------------
module dtcf_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  dtcf_pkg::cfg_t                   cfg,
    input  dtcf_pkg::ctrl_cmd_t              cmd,
    input  logic [dtcf_pkg::SAMPLE_BITS-1:0] s_sample,
    input  logic                             s_first_sample,
    output logic [dtcf_pkg::SAMPLE_BITS-1:0] m_filtered
);
    import dtcf_pkg::*;

    logic [SAMPLE_BITS-1:0] smp_reg;
    logic                   first_reg;
    logic [SAMPLE_BITS-1:0] res_reg;
    logic [SAMPLE_BITS-1:0] res_next;
    logic [SAMPLE_BITS-1:0] hl_reg;
    logic [SAMPLE_BITS-1:0] hl_next;
    logic [SAMPLE_BITS-1:0] hs_reg;
    logic [SAMPLE_BITS-1:0] hs_next;
    logic [SAMPLE_BITS-1:0] rem_long_reg;
    logic [SAMPLE_BITS-1:0] rem_long_next;
    logic [SAMPLE_BITS-1:0] rem_short_reg;
    logic [SAMPLE_BITS-1:0] rem_short_next;
    logic [SAMPLE_BITS-1:0] filt_reg;

    logic [SAMPLE_BITS-1:0] rem_l_eff;
    logic [SAMPLE_BITS-1:0] rem_s_eff;
    logic [SAMPLE_BITS:0]   corr_sum;
    logic [SAMPLE_BITS-1:0] corr;
    logic [COEF_BITS-1:0]   al_l;
    logic [COEF_BITS-1:0]   al_s;
    logic [COEF_BITS-1:0]   lam_l;
    logic [COEF_BITS-1:0]   lam_s;
    logic [PROD_BITS-1:0]   prod_al;
    logic [PROD_BITS-1:0]   prod_as;
    logic [PROD_BITS-1:0]   prod_ll;
    logic [PROD_BITS-1:0]   prod_ls;
    logic [SAMPLE_BITS:0]   hl_sum;
    logic [SAMPLE_BITS:0]   hs_sum;

    // Coefficients with their fixed high bits.
    assign al_l  = {1'b0, cfg.alpha_long};
    assign al_s  = cfg.use_short ? (ALPHA_S_FIXED | {1'b0, cfg.alpha_short_param})
                                 : '0;
    assign lam_l = LAM_L_FIXED | {2'b00, cfg.lambda_long_param};
    assign lam_s = LAM_S_FIXED | {2'b00, cfg.lambda_short_param};

    // First stage: a first sample restarts both remainders from software values.
    assign rem_l_eff = first_reg ? cfg.init_rem_long  : rem_long_reg;
    assign rem_s_eff = first_reg ? cfg.init_rem_short : rem_short_reg;

    // Correction is the saturated sum of the remainders; the output is clamped at zero.
    assign corr_sum = {1'b0, rem_l_eff} + {1'b0, rem_s_eff};
    assign corr     = corr_sum[SAMPLE_BITS] ? SAMPLE_MAX : corr_sum[SAMPLE_BITS-1:0];
    assign res_next = (smp_reg > corr) ? (smp_reg - corr) : '0;

    // Each remainder absorbs alpha times the output, saturated.
    assign prod_al = PROD_BITS'(al_l) * PROD_BITS'(res_next);
    assign prod_as = PROD_BITS'(al_s) * PROD_BITS'(res_next);
    assign hl_sum  = {1'b0, rem_l_eff} + {1'b0, prod_al[PROD_BITS-1:COEF_FRAC_BITS]};
    assign hs_sum  = {1'b0, rem_s_eff} + {1'b0, prod_as[PROD_BITS-1:COEF_FRAC_BITS]};
    assign hl_next = hl_sum[SAMPLE_BITS] ? SAMPLE_MAX : hl_sum[SAMPLE_BITS-1:0];
    assign hs_next = hs_sum[SAMPLE_BITS] ? SAMPLE_MAX : hs_sum[SAMPLE_BITS-1:0];

    // Second stage: decay by lambda. The scaled product stays within the sample range.
    assign prod_ll        = PROD_BITS'(lam_l) * PROD_BITS'(hl_reg);
    assign prod_ls        = PROD_BITS'(lam_s) * PROD_BITS'(hs_reg);
    assign rem_long_next  = prod_ll[PROD_BITS-1:COEF_FRAC_BITS];
    assign rem_short_next = prod_ls[PROD_BITS-1:COEF_FRAC_BITS];

    // Filter state: the remainders reset to zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_long_reg  <= '0;
            rem_short_reg <= '0;
        end else if (cmd.finish) begin
            rem_long_reg  <= rem_long_next;
            rem_short_reg <= rem_short_next;
        end
    end

    // Payload registers of the sample, intermediate and result.
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            smp_reg   <= s_sample;
            first_reg <= s_first_sample;
        end
        if (cmd.calc_h) begin
            res_reg <= res_next;
            hl_reg  <= hl_next;
            hs_reg  <= hs_next;
        end
        if (cmd.finish) begin
            filt_reg <= res_reg;
        end
    end

    assign m_filtered = filt_reg;

endmodule

// ===== hw/rtl/digital_tail_cancellation_filter_core.sv =====
// ----------------------------------------------------------------------------
// digital_tail_cancellation_filter_core: two-exponential tail cancellation
// The sample is registered, passes the first multiply stage, then the second,
// which loads the result register; each remainder update takes the alpha and
// lambda multiplies in turn. A new sample may enter while the last finishes.
// A result waiting in the output register stalls the second multiply stage.
// Reset (aresetn low, synchronous) clears config, state and both remainders.
// ----------------------------------------------------------------------------
module digital_tail_cancellation_filter_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [dtcf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [dtcf_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [dtcf_pkg::SAMPLE_BITS-1:0]   s_sample,
    input  logic                               s_first_sample,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [dtcf_pkg::SAMPLE_BITS-1:0]   m_filtered
);
    import dtcf_pkg::*;

    cfg_t      cfg;
    ctrl_cmd_t cmd;

    // Configuration bank.
    dtcf_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Sequencing controller.
    dtcf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Filter datapath.
    dtcf_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .cmd            (cmd),
        .s_sample       (s_sample),
        .s_first_sample (s_first_sample),
        .m_filtered     (m_filtered)
    );

endmodule

// ===== hw/rtl/dtcf_checker.sv =====
// ----------------------------------------------------------------------------
// dtcf_checker: port-level assertions of the filter core
// Watches the transfers on both channels and the sequencing they imply.
// ----------------------------------------------------------------------------
module dtcf_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               cfg_wr_en,
    input logic [dtcf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input logic [dtcf_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic [dtcf_pkg::SAMPLE_BITS-1:0]   s_sample,
    input logic                               s_first_sample,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [dtcf_pkg::SAMPLE_BITS-1:0]   m_filtered
);
    import dtcf_pkg::*;

    logic in_xfer;
    logic cfg_seen;

    assign in_xfer  = s_valid && s_ready;
    assign cfg_seen = cfg_wr_en && (cfg_index <= CFG_INIT_SHORT) && (cfg_wdata != '0);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_filtered))
        else $error("result changed while stalled");

    // The first multiply stage never takes a second sample.
    a_busy_after_xfer: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> !s_ready)
        else $error("input accepted in the first multiply stage");

    // No result is shown straight after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A zero sample filters to zero once the output register is free.
    a_zero_in_zero_out: assert property (@(posedge aclk) disable iff (!aresetn || cfg_seen)
        (in_xfer && (s_sample == '0)) ##2 (!m_valid || m_ready) |=>
            m_valid && (m_filtered == '0))
        else $error("zero sample did not give a zero result");

endmodule

bind digital_tail_cancellation_filter_core dtcf_checker u_dtcf_checker (.*);
